>>> rtl/core/xml_empty_element_expander_top_macros.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef XML_EMPTY_ELEMENT_EXPANDER_TOP_MACROS_SVH
`define XML_EMPTY_ELEMENT_EXPANDER_TOP_MACROS_SVH

// same-cycle implication
`define XEE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define XEE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/xee_pkg.sv
`default_nettype none
package xee_pkg;

	localparam int NAME_CAPACITY = 19;
	localparam int LEN_W = $clog2(NAME_CAPACITY + 1);
	localparam int IDX_W = (NAME_CAPACITY > 1) ? $clog2(NAME_CAPACITY) : 1;

	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_SL = 8'h2F;
	localparam logic [7:0] CH_SP = 8'h20;

	// where the data of an emitted beat comes from
	typedef enum logic [2:0] {
		SRC_IN,
		SRC_BYTE,
		SRC_SLASH,
		SRC_LT,
		SRC_GT,
		SRC_NAME
	} src_t;

	typedef struct packed {
		logic accept;
		logic push;
		src_t src;
		logic run_last;
		logic too_long;
		logic idx_inc;
	} cmd_t;

	typedef struct packed {
		logic pend;
		logic is_gt;
		logic ovf;
		logic hold;
		logic rep_zero;
		logic name_done;
	} sts_t;

	typedef struct packed {
		logic [7:0] data;
		logic run_last;
		logic msg_end;
		logic too_long;
	} beat_t;

endpackage
`default_nettype wire

>>> rtl/core/xml_empty_element_expander_top.sv
// Empty-element expander: XML text in, one byte per beat, canonical text out.
// Input channel in_valid/in_ready carries in_byte and in_last (final byte of a
// message). Output channel out_valid/out_ready carries out_byte, out_run_last
// (last beat caused by one input beat), out_message_end and out_name_too_long.
// Bytes pass through unchanged except that "/>" after a kept tag name becomes
// "></name>", or stays "/>" flagged too long if the name overflowed; a slash
// after a kept name gives no output until the next byte. The first output beat
// of an input byte is valid the cycle after the input is accepted. Throughput
// is one byte per cycle for plain text and one beat per cycle in an expansion,
// each given queue room; in_ready is low until a byte's last beat is pushed.
// Reset clears all tag state at once; no clearing pass is needed, and the same
// state is cleared after every beat with in_last set.
// A two-beat output queue sits between the sequencer and the output port: when
// the receiver stalls the queue fills, and in_ready drops until a beat leaves it.
`default_nettype none
module xml_empty_element_expander_top import xee_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] in_byte,
	input wire logic in_last,
	output logic out_valid,
	input wire logic out_ready,
	output logic [7:0] out_byte,
	output logic out_run_last,
	output logic out_message_end,
	output logic out_name_too_long
);

	cmd_t cmd;
	sts_t sts;
	beat_t wr_beat;
	beat_t rd_beat;
	logic room;

	xee_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.room(room),
		.sts(sts),
		.cmd(cmd)
	);

	xee_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_byte(in_byte),
		.in_last(in_last),
		.cmd(cmd),
		.sts(sts),
		.beat(wr_beat)
	);

	xee_obuf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd.push),
		.wr_beat(wr_beat),
		.pop_ready(out_ready),
		.room(room),
		.rd_valid(out_valid),
		.rd_beat(rd_beat)
	);

	assign out_byte = rd_beat.data;
	assign out_run_last = rd_beat.run_last;
	assign out_message_end = rd_beat.msg_end;
	assign out_name_too_long = rd_beat.too_long;

endmodule
`default_nettype wire

>>> rtl/core/xee_obuf.sv
`default_nettype none
module xee_obuf import xee_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire beat_t wr_beat,
	input wire logic pop_ready,
	output logic room,
	output logic rd_valid,
	output beat_t rd_beat
);

	// two-entry output queue
	beat_t mem_q [2];
	logic [1:0] count_q;
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic pop;

	assign rd_valid = (count_q != 2'd0);
	assign room = (count_q != 2'd2);
	assign pop = rd_valid && pop_ready;
	assign rd_beat = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/xee_dp.sv
`default_nettype none
module xee_dp import xee_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [7:0] in_byte,
	input wire logic in_last,
	input wire cmd_t cmd,
	output sts_t sts,
	output beat_t beat
);

	logic cap_q;
	logic [LEN_W-1:0] len_q;
	logic ovf_q;
	logic slash_q;
	logic [7:0] byte_q;
	logic last_q;
	logic [LEN_W-1:0] rep_len_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0] name_q [NAME_CAPACITY];

	logic is_lt;
	logic is_gt;
	logic is_sp;
	logic is_sl;
	logic kept;
	logic hold;
	logic expand;
	logic room_left;
	logic name_wr;

	assign is_lt = (in_byte == CH_LT);
	assign is_gt = (in_byte == CH_GT);
	assign is_sp = (in_byte == CH_SP);
	assign is_sl = (in_byte == CH_SL);
	assign kept = (len_q != '0) || ovf_q;
	assign hold = !cap_q && is_sl && kept && !in_last;
	assign expand = slash_q && is_gt;
	assign room_left = (len_q < LEN_W'(NAME_CAPACITY));
	assign name_wr = cmd.accept && cap_q && !is_sp && !is_gt && room_left;

	assign sts.pend = slash_q;
	assign sts.is_gt = is_gt;
	assign sts.ovf = ovf_q;
	assign sts.hold = hold;
	assign sts.rep_zero = (rep_len_q == '0);
	assign sts.name_done = ((LEN_W'(idx_q) + LEN_W'(1)) == rep_len_q);

	always_comb begin
		case (cmd.src)
			SRC_IN: beat.data = in_byte;
			SRC_BYTE: beat.data = byte_q;
			SRC_SLASH: beat.data = CH_SL;
			SRC_LT: beat.data = CH_LT;
			SRC_GT: beat.data = CH_GT;
			SRC_NAME: beat.data = name_q[idx_q];
			default: beat.data = in_byte;
		endcase
		beat.run_last = cmd.run_last;
		beat.msg_end = cmd.run_last && (cmd.accept ? in_last : last_q);
		beat.too_long = cmd.too_long;
	end

	always_ff @(posedge clk) begin
		if (name_wr) begin
			name_q[len_q[IDX_W-1:0]] <= in_byte;
		end
		if (cmd.accept) begin
			byte_q <= in_byte;
			last_q <= in_last;
			rep_len_q <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 1'b0;
			len_q <= '0;
			ovf_q <= 1'b0;
			slash_q <= 1'b0;
			idx_q <= '0;
		end else if (cmd.accept) begin
			idx_q <= '0;
			slash_q <= hold;
			if (in_last) begin
				cap_q <= 1'b0;
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (expand) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (cap_q) begin
				if (is_sp) begin
					cap_q <= 1'b0;
				end else if (is_gt) begin
					cap_q <= 1'b0;
					len_q <= '0;
					ovf_q <= 1'b0;
				end else if (room_left) begin
					len_q <= len_q + LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end else if (is_lt) begin
				cap_q <= 1'b1;
				len_q <= '0;
				ovf_q <= 1'b0;
			end
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/xee_ctrl.sv
`default_nettype none
`include "xml_empty_element_expander_top_macros.svh"
module xee_ctrl import xee_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic room,
	input wire sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_BYTE   = 7'b0000010,
		ST_OVF_GT = 7'b0000100,
		ST_X_LT   = 7'b0001000,
		ST_X_SL   = 7'b0010000,
		ST_X_NAME = 7'b0100000,
		ST_X_GT   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic accept;

	assign in_ready = (state_q == ST_IDLE) && room;
	assign accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd = '{accept: accept, push: 1'b0, src: SRC_IN, run_last: 1'b0,
			too_long: 1'b0, idx_inc: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sts.pend && sts.is_gt) begin
						cmd.push = 1'b1;
						if (sts.ovf) begin
							cmd.src = SRC_SLASH;
							cmd.too_long = 1'b1;
							state_d = ST_OVF_GT;
						end else begin
							cmd.src = SRC_GT;
							state_d = ST_X_LT;
						end
					end else if (sts.pend) begin
						// release the held slash, then the byte unless it is held again
						cmd.push = 1'b1;
						cmd.src = SRC_SLASH;
						if (sts.hold) begin
							cmd.run_last = 1'b1;
						end else begin
							state_d = ST_BYTE;
						end
					end else if (!sts.hold) begin
						cmd.push = 1'b1;
						cmd.src = SRC_IN;
						cmd.run_last = 1'b1;
					end
				end
			end
			ST_BYTE: begin
				if (room) begin
					cmd.push = 1'b1;
					cmd.src = SRC_BYTE;
					cmd.run_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_OVF_GT: begin
				if (room) begin
					cmd.push = 1'b1;
					cmd.src = SRC_GT;
					cmd.too_long = 1'b1;
					cmd.run_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_X_LT: begin
				if (room) begin
					cmd.push = 1'b1;
					cmd.src = SRC_LT;
					state_d = ST_X_SL;
				end
			end
			ST_X_SL: begin
				if (room) begin
					cmd.push = 1'b1;
					cmd.src = SRC_SLASH;
					state_d = sts.rep_zero ? ST_X_GT : ST_X_NAME;
				end
			end
			ST_X_NAME: begin
				if (room) begin
					cmd.push = 1'b1;
					cmd.src = SRC_NAME;
					cmd.idx_inc = 1'b1;
					if (sts.name_done) begin
						state_d = ST_X_GT;
					end
				end
			end
			ST_X_GT: begin
				if (room) begin
					cmd.push = 1'b1;
					cmd.src = SRC_GT;
					cmd.run_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`XEE_ASSERT_IMPL(a_push_has_room, cmd.push, room, "beat pushed into a full output queue")
	`XEE_ASSERT_NEXT(a_expand_start, accept && sts.pend && sts.is_gt && !sts.ovf, state_q == ST_X_LT, "expansion did not start after a slash and close")
	`XEE_ASSERT_IMPL(a_name_entry, state_q == ST_X_NAME, $past(state_q) == ST_X_SL || $past(state_q) == ST_X_NAME, "name replay entered out of order")

endmodule
`default_nettype wire

>>> verif/xml_empty_element_expander_checker.sv
`timescale 1ns / 1ps
module xml_empty_element_expander_checker import xee_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [7:0] in_byte,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] out_byte,
	input logic out_run_last,
	input logic out_message_end,
	input logic out_name_too_long,
	output int fail_count,
	output int n_waiting
);

	// predicted tag state
	logic in_tag_name;
	logic [7:0] tag_name [NAME_CAPACITY];
	int tag_len;
	logic tag_overflow;
	logic slash_hold;

	beat_t canon_q [$];

	function automatic beat_t make_beat(input logic [7:0] data, input logic too_long);
		beat_t bt;
		bt.data = data;
		bt.run_last = 1'b0;
		bt.msg_end = 1'b0;
		bt.too_long = too_long;
		return bt;
	endfunction

	task automatic clear_tag_state();
		in_tag_name = 1'b0;
		tag_len = 0;
		tag_overflow = 1'b0;
		slash_hold = 1'b0;
	endtask

	// expected beats for one accepted input byte
	task automatic expand_byte(input logic [7:0] b, input logic last);
		int base;
		logic done;
		beat_t bt;
		base = canon_q.size();
		done = 1'b0;
		if (slash_hold) begin
			slash_hold = 1'b0;
			if (b == CH_GT) begin
				if (tag_overflow) begin
					canon_q.push_back(make_beat(CH_SL, 1'b1));
					canon_q.push_back(make_beat(CH_GT, 1'b1));
				end else begin
					canon_q.push_back(make_beat(CH_GT, 1'b0));
					canon_q.push_back(make_beat(CH_LT, 1'b0));
					canon_q.push_back(make_beat(CH_SL, 1'b0));
					for (int i = 0; i < tag_len; i++)
						canon_q.push_back(make_beat(tag_name[i], 1'b0));
					canon_q.push_back(make_beat(CH_GT, 1'b0));
				end
				tag_len = 0;
				tag_overflow = 1'b0;
				done = 1'b1;
			end else begin
				canon_q.push_back(make_beat(CH_SL, 1'b0));
			end
		end
		if (!done) begin
			if (in_tag_name) begin
				if (b == CH_SP) begin
					in_tag_name = 1'b0;
				end else if (b == CH_GT) begin
					in_tag_name = 1'b0;
					tag_len = 0;
					tag_overflow = 1'b0;
				end else if (tag_len < NAME_CAPACITY) begin
					tag_name[tag_len] = b;
					tag_len++;
				end else begin
					tag_overflow = 1'b1;
				end
				canon_q.push_back(make_beat(b, 1'b0));
			end else if (b == CH_LT) begin
				in_tag_name = 1'b1;
				tag_len = 0;
				tag_overflow = 1'b0;
				canon_q.push_back(make_beat(b, 1'b0));
			end else if (b == CH_SL && (tag_len != 0 || tag_overflow) && !last) begin
				slash_hold = 1'b1;
			end else begin
				canon_q.push_back(make_beat(b, 1'b0));
			end
		end
		if (canon_q.size() > base) begin
			bt = canon_q.pop_back();
			bt.run_last = 1'b1;
			bt.msg_end = last;
			canon_q.push_back(bt);
		end
		if (last)
			clear_tag_state();
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		if (!arst_n) begin
			clear_tag_state();
			canon_q.delete();
			fail_count = 0;
			n_waiting = 0;
		end else begin
			// an input beat shows up on the output in the cycle after its acceptance at the earliest
			if (out_valid && out_ready) begin
				if (canon_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected beat byte %h run_last %b msg_end %b too_long %b",
							$realtime, out_byte, out_run_last, out_message_end,
							out_name_too_long);
					fail_count++;
				end else begin
					want = canon_q.pop_front();
					if (out_byte !== want.data || out_run_last !== want.run_last ||
						out_message_end !== want.msg_end ||
						out_name_too_long !== want.too_long) begin
						if (fail_count < 10)
							$display("%0t: beat mismatch, expected %h/%b/%b/%b got %h/%b/%b/%b",
								$realtime, want.data, want.run_last, want.msg_end,
								want.too_long, out_byte, out_run_last, out_message_end,
								out_name_too_long);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expand_byte(in_byte, in_last);
			n_waiting = canon_q.size();
		end
	end

endmodule

>>> verif/xml_empty_element_expander_top_tb.sv
`timescale 1ns / 1ps
module xml_empty_element_expander_top_tb import xee_pkg::*;;

	localparam int QUIET_LIMIT = 4000;
	localparam int N_ITEMS = 420;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] in_byte;
	logic in_last;
	logic out_valid;
	logic out_ready;
	logic [7:0] out_byte;
	logic out_run_last;
	logic out_message_end;
	logic out_name_too_long;

	int fail_count;
	int n_waiting;

	int n_sent;
	int burst_left;
	bit gaps_on;
	bit stall_req;
	bit stall_done;
	logic [7:0] msg_q [$];

	xml_empty_element_expander_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.out_run_last(out_run_last),
		.out_message_end(out_message_end),
		.out_name_too_long(out_name_too_long)
	);

	xml_empty_element_expander_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.out_run_last(out_run_last),
		.out_message_end(out_message_end),
		.out_name_too_long(out_name_too_long),
		.fail_count(fail_count),
		.n_waiting(n_waiting)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one input beat; called at a falling edge, returns at a falling edge
	task automatic offer(input logic [7:0] b, input logic last);
		if (burst_left == 0) begin
			if (gaps_on && $urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_q.push_back(s[i]);
	endtask

	// sends the queued message with in_last on its final byte
	task automatic send_msg();
		for (int i = 0; i < msg_q.size(); i++)
			offer(msg_q[i], i == msg_q.size() - 1);
		msg_q.delete();
	endtask

	function automatic logic [7:0] name_char();
		logic [7:0] c;
		case ($urandom_range(0, 15))
			0: c = CH_LT;
			1: c = CH_SL;
			2, 3: begin
				c = 8'($urandom_range(0, 255));
				if (c == CH_SP || c == CH_GT)
					c = 8'h7A;
			end
			default: c = 8'h61 + 8'($urandom_range(0, 25));
		endcase
		return c;
	endfunction

	function automatic logic [7:0] attr_char();
		logic [7:0] c;
		case ($urandom_range(0, 11))
			0: c = CH_SP;
			1: c = 8'h3D;
			2: c = 8'h22;
			3: c = CH_SL;
			default: c = 8'h61 + 8'($urandom_range(0, 25));
		endcase
		return c;
	endfunction

	// mostly short names, some at and past the buffer size
	task automatic put_name();
		int len;
		case ($urandom_range(0, 19))
			0: len = 0;
			14, 15, 16: len = $urandom_range(7, 17);
			17: len = $urandom_range(NAME_CAPACITY - 1, NAME_CAPACITY);
			18: len = NAME_CAPACITY + 1;
			19: len = $urandom_range(NAME_CAPACITY + 2, NAME_CAPACITY + 7);
			default: len = $urandom_range(1, 6);
		endcase
		for (int i = 0; i < len; i++)
			msg_q.push_back(name_char());
	endtask

	task automatic put_attrs();
		repeat ($urandom_range(0, 5))
			msg_q.push_back(attr_char());
	endtask

	initial begin : stimulus
		int segs;
		bit drained;
		in_valid = 1'b0;
		in_byte = 8'h00;
		in_last = 1'b0;
		arst_n = 1'b0;
		n_sent = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		stall_req = 1'b0;
		drained = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// byte extremes, tag name with '<' and '/' expanded, empty name,
		// released slash, new tag over a kept name, slash on the last byte
		msg_q.push_back(8'h00);
		msg_q.push_back(8'hFF);
		push_str("<</ />< /><q /z<m /");
		send_msg();
		// '>' ends the capture and drops the name
		push_str("<p>/>");
		send_msg();

		while (n_sent < N_ITEMS) begin
			gaps_on = ($urandom_range(0, 4) != 0);
			segs = $urandom_range(1, 5);
			repeat (segs) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						msg_q.push_back(CH_LT);
						put_name();
						msg_q.push_back(CH_SP);
						put_attrs();
						msg_q.push_back(CH_SL);
						msg_q.push_back(CH_GT);
					end
					4: begin
						msg_q.push_back(CH_LT);
						put_name();
						msg_q.push_back(CH_SL);
						msg_q.push_back(CH_GT);
					end
					5: begin
						msg_q.push_back(CH_LT);
						put_name();
						msg_q.push_back(CH_GT);
					end
					6: begin
						msg_q.push_back(CH_LT);
						put_name();
						msg_q.push_back(CH_SP);
						put_attrs();
						msg_q.push_back(CH_GT);
					end
					7: begin
						repeat ($urandom_range(1, 6))
							msg_q.push_back(8'($urandom_range(0, 255)));
					end
					8: begin
						repeat ($urandom_range(1, 6)) begin
							case ($urandom_range(0, 4))
								0: msg_q.push_back(CH_LT);
								1: msg_q.push_back(CH_GT);
								2: msg_q.push_back(CH_SL);
								3: msg_q.push_back(CH_SP);
								default: msg_q.push_back(8'($urandom_range(0, 255)));
							endcase
						end
					end
					default: begin
						// slash that is not followed by '>'
						msg_q.push_back(CH_LT);
						put_name();
						msg_q.push_back(CH_SP);
						msg_q.push_back(CH_SL);
						msg_q.push_back(attr_char());
						msg_q.push_back(CH_GT);
					end
				endcase
			end
			send_msg();
			if (n_sent > 120)
				stall_req = 1'b1;
			if (!drained && stall_done && n_sent > 280) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (n_waiting != 0)
					@(negedge clk);
				drained = 1'b1;
			end
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (n_waiting != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : receiver
		int mode;
		int span;
		out_ready = 1'b0;
		stall_done = 1'b0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(40, 200);
			for (int c = 0; c < span; c++) begin
				@(negedge clk);
				// long hold-off so the output queue fills and input stalls
				if (stall_req && !stall_done) begin
					out_ready <= 1'b0;
					repeat (300) @(negedge clk);
					stall_done = 1'b1;
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (c % 3 != 2);
				endcase
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

endmodule
